// ----- hw/rtl/dtw_pkg.sv -----
// distance taper weighting: shared widths, mode codes, register indexes
// and the side-band record that travels down the pipeline
// no dependencies
package dtw_pkg;

  localparam int VALUE_W = 16;
  localparam int DIST_W = 16;
  localparam int LEN_W = 16;
  localparam int FRAC = 16;
  localparam int Q_W = LEN_W + 1;
  localparam int T_W = 21;
  localparam int RECIP_SH = 36;
  localparam int W_W = FRAC + 1;
  localparam int P_W = 22;
  localparam int S_W = 30;
  localparam int CMP_W = (DIST_W > Q_W) ? DIST_W : Q_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [W_W-1:0] ONE_Q16 = W_W'(1 << FRAC);

  localparam logic [CFG_IDX_W-1:0] REG_SUPPORT_LENGTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TAPER_MODE = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    MODE_NONE      = 2'd0,
    MODE_LINEAR    = 2'd1,
    MODE_SPHERICAL = 2'd2,
    MODE_GC        = 2'd3
  } taper_mode_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    taper_mode_t               mode;
    logic                      in_range;
  } side_t;

endpackage

// ----- hw/rtl/dtw_if.sv -----
// handshake channels for samples, results and register writes
// depends on dtw_pkg
interface dtw_in_if import dtw_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] sample_value;
  logic [DIST_W-1:0]         distance;
  modport source(output valid, sample_value, distance, input ready);
  modport sink(input valid, sample_value, distance, output ready);
endinterface

interface dtw_out_if import dtw_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] weighted_value;
  modport source(output valid, weighted_value, input ready);
  modport sink(input valid, weighted_value, output ready);
endinterface

interface dtw_cfg_if import dtw_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- hw/rtl/dtw_ratio_div.sv -----
// pipelined restoring divider for the ratio q = distance * 2^16 / length
// one quotient bit per stage; depends on dtw_pkg
module dtw_ratio_div import dtw_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_vld,
  input  side_t            in_side,
  input  logic [Q_W-1:0]   in_d,
  input  logic [LEN_W-1:0] in_len,
  output logic             out_vld,
  output side_t            out_side,
  output logic [Q_W-1:0]   out_q
);

  logic             vld  [Q_W];
  side_t            side [Q_W];
  logic [Q_W-1:0]   rem  [Q_W];
  logic [LEN_W-1:0] len  [Q_W];
  logic [Q_W-1:0]   qacc [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    logic             v_in;
    side_t            s_in;
    logic [Q_W-1:0]   r_in;
    logic [LEN_W-1:0] l_in;
    logic [Q_W-1:0]   q_in;
    logic             ge;
    logic [Q_W-1:0]   r_sub;

    if (i == 0) begin : g_first
      assign v_in = in_vld;
      assign s_in = in_side;
      assign r_in = in_d;
      assign l_in = in_len;
      assign q_in = '0;
    end else begin : g_next
      assign v_in = vld[i-1];
      assign s_in = side[i-1];
      assign r_in = rem[i-1];
      assign l_in = len[i-1];
      assign q_in = qacc[i-1];
    end

    // for in-range distances the partial remainder stays below twice the length
    assign ge = r_in >= {1'b0, l_in};
    assign r_sub = ge ? r_in - {1'b0, l_in} : r_in;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[i] <= s_in;
        len[i]  <= l_in;
        rem[i]  <= {r_sub[LEN_W-1:0], 1'b0};
        qacc[i] <= {q_in[Q_W-2:0], ge};
      end
    end
  end

  assign out_vld  = vld[Q_W-1];
  assign out_side = side[Q_W-1];
  assign out_q    = qacc[Q_W-1];

endmodule

// ----- hw/rtl/dtw_recip_div.sv -----
// pipelined restoring divider for t = round(16 * 2^32 / q), the 16/r term
// one quotient bit per stage, q passed along; depends on dtw_pkg
module dtw_recip_div import dtw_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_vld,
  input  side_t          in_side,
  input  logic [Q_W-1:0] in_q,
  output logic           out_vld,
  output side_t          out_side,
  output logic [Q_W-1:0] out_q,
  output logic [T_W-1:0] out_t
);

  localparam logic [Q_W-1:0] REM_INIT = Q_W'(1 << (RECIP_SH - T_W));

  logic           vld  [T_W];
  side_t          side [T_W];
  logic [Q_W-1:0] rem  [T_W];
  logic [Q_W-1:0] qv   [T_W];
  logic [T_W-1:0] tacc [T_W];

  for (genvar i = 0; i < T_W; i++) begin : g_stage
    localparam int B = T_W - 1 - i;
    logic           v_in;
    side_t          s_in;
    logic [Q_W-1:0] r_in;
    logic [Q_W-1:0] q_in;
    logic [T_W-1:0] t_in;
    logic           nbit;
    logic [Q_W:0]   r_sh;
    logic           ge;
    logic [Q_W:0]   r_sub;

    if (i == 0) begin : g_first
      assign v_in = in_vld;
      assign s_in = in_side;
      assign r_in = REM_INIT;
      assign q_in = in_q;
      assign t_in = '0;
    end else begin : g_next
      assign v_in = vld[i-1];
      assign s_in = side[i-1];
      assign r_in = rem[i-1];
      assign q_in = qv[i-1];
      assign t_in = tacc[i-1];
    end

    // numerator bit: the rounding half q/2 sits in the low bits
    if (B + 1 < Q_W) begin : g_nbit
      assign nbit = q_in[B+1];
    end else begin : g_zero
      assign nbit = 1'b0;
    end

    assign r_sh  = {r_in, nbit};
    assign ge    = r_sh >= {1'b0, q_in};
    assign r_sub = ge ? r_sh - {1'b0, q_in} : r_sh;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[i] <= s_in;
        qv[i]   <= q_in;
        rem[i]  <= r_sub[Q_W-1:0];
        tacc[i] <= {t_in[T_W-2:0], ge};
      end
    end
  end

  assign out_vld  = vld[T_W-1];
  assign out_side = side[T_W-1];
  assign out_q    = qv[T_W-1];
  assign out_t    = tacc[T_W-1];

endmodule

// ----- hw/rtl/dtw_weight.sv -----
// taper weight from the ratio: powers, polynomial sums, divide by 24, select
// seven register stages; depends on dtw_pkg
module dtw_weight import dtw_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_vld,
  input  side_t          in_side,
  input  logic [Q_W-1:0] in_q,
  input  logic [T_W-1:0] in_t,
  output logic           out_vld,
  output side_t          out_side,
  output logic [W_W-1:0] out_w
);

  localparam int X_W = 18;
  localparam int K_W = 20;
  localparam logic [K_W-1:0] RECIP3 = K_W'(349525);
  localparam logic signed [S_W-1:0] GC_LO_K = S_W'(24 * 65536);
  localparam logic signed [S_W-1:0] GC_HI_K = S_W'(96 * 65536);
  localparam logic signed [S_W-1:0] SPH_K = S_W'(2 * 65536);
  localparam logic signed [S_W-1:0] GC_RND = S_W'(12);
  localparam logic signed [S_W-1:0] GC_SAT = S_W'(24 * 65537);
  localparam logic signed [S_W-1:0] ONE_S = S_W'(65536);

  function automatic logic [P_W-1:0] mul_q16(input logic [P_W-1:0] a,
                                             input logic [Q_W-1:0] b);
    logic [P_W+Q_W-1:0] pr;
    pr = a * b + (P_W+Q_W)'(32768);
    return pr[FRAC +: P_W];
  endfunction

  // power stages
  logic           p_vld  [4];
  side_t          p_side [4];
  logic [Q_W-1:0] p_q    [4];
  logic [T_W-1:0] p_t    [4];
  logic [P_W-1:0] p_pow  [4];
  logic [P_W-1:0] p2, p3, p4;

  for (genvar i = 0; i < 4; i++) begin : g_pow
    logic           v_in;
    side_t          s_in;
    logic [Q_W-1:0] q_in;
    logic [T_W-1:0] t_in;
    logic [P_W-1:0] a_in;

    if (i == 0) begin : g_first
      assign v_in = in_vld;
      assign s_in = in_side;
      assign q_in = in_q;
      assign t_in = in_t;
      assign a_in = P_W'(in_q);
    end else begin : g_next
      assign v_in = p_vld[i-1];
      assign s_in = p_side[i-1];
      assign q_in = p_q[i-1];
      assign t_in = p_t[i-1];
      assign a_in = p_pow[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        p_vld[i] <= 1'b0;
      end else if (en) begin
        p_vld[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        p_side[i] <= s_in;
        p_q[i]    <= q_in;
        p_t[i]    <= t_in;
        p_pow[i]  <= mul_q16(a_in, q_in);
      end
    end
  end

  // lower powers ride along with the last one
  always_ff @(posedge clk) begin
    if (en) begin
      p2 <= p_pow[0];
      p3 <= p2;
      p4 <= p3;
    end
  end

  // sums: after the fourth power stage the held powers line up as
  // p2 (three stages back), p3 (two back), p4 (one back) and p5 = p_pow[3]
  logic [P_W-1:0] d_p3, h_p3, h_p4;
  always_ff @(posedge clk) begin
    if (en) begin
      d_p3 <= p_pow[1];
      h_p3 <= d_p3;
      h_p4 <= p_pow[2];
    end
  end

  logic signed [S_W-1:0] e_q, e_t, e_p2, e_p3, e_p4, e_p5;
  logic signed [S_W-1:0] gc_lo, gc_hi, sph;

  // the sums below use values from matching items only
  assign e_q  = signed'(S_W'(p_q[3]));
  assign e_t  = signed'(S_W'(p_t[3]));
  assign e_p2 = signed'(S_W'(p4));
  assign e_p3 = signed'(S_W'(h_p3));
  assign e_p4 = signed'(S_W'(h_p4));
  assign e_p5 = signed'(S_W'(p_pow[3]));

  assign gc_lo = S_W'(GC_LO_K - 40 * e_p2 + 15 * e_p3 + 12 * e_p4 - 6 * e_p5);
  assign gc_hi = S_W'(GC_HI_K - 120 * e_q + 40 * e_p2 + 15 * e_p3 - 12 * e_p4
               + 2 * e_p5 - e_t);
  assign sph   = S_W'(SPH_K - 3 * e_q + e_p3);

  logic                  s1_vld;
  side_t                 s1_side;
  logic signed [S_W-1:0] s1_gc;
  logic signed [S_W-1:0] s1_sph;
  logic [W_W-1:0]        s1_lin;
  logic                  s1_lt1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= p_vld[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side <= p_side[3];
      s1_gc   <= p_q[3][Q_W-1] ? gc_hi : gc_lo;
      s1_sph  <= sph;
      s1_lin  <= ONE_Q16 - W_W'(p_q[3]);
      s1_lt1  <= !p_q[3][Q_W-1];
    end
  end

  // divide by 24: add the rounding half, divide by 8 and by 3 via a reciprocal, then clamp
  logic signed [S_W-1:0] gc_r;
  logic signed [S_W-1:0] sph_half;
  logic [W_W-1:0]        sph_w;
  logic [W_W-1:0]        w_other;
  logic                  sup_ok;

  assign gc_r     = s1_gc + GC_RND;
  assign sph_half = (s1_sph + S_W'(1)) >>> 1;
  assign sup_ok   = s1_side.in_range && s1_lt1;

  always_comb begin
    if (s1_sph < 0) begin
      sph_w = '0;
    end else if (sph_half > ONE_S) begin
      sph_w = ONE_Q16;
    end else begin
      sph_w = sph_half[W_W-1:0];
    end
  end

  always_comb begin
    case (s1_side.mode)
      MODE_NONE:      w_other = ONE_Q16;
      MODE_LINEAR:    w_other = sup_ok ? s1_lin : '0;
      MODE_SPHERICAL: w_other = sup_ok ? sph_w : '0;
      default:        w_other = '0;
    endcase
  end

  logic               s2_vld;
  side_t              s2_side;
  logic [X_W-1:0]     s2_x;
  logic [X_W+K_W-1:0] s2_prod;
  logic               s2_zero;
  logic               s2_sat;
  logic [W_W-1:0]     s2_other;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_side  <= s1_side;
      s2_x     <= gc_r[3 +: X_W];
      s2_prod  <= gc_r[3 +: X_W] * RECIP3;
      s2_zero  <= (s1_gc < 0) || !s1_side.in_range;
      s2_sat   <= gc_r >= GC_SAT;
      s2_other <= w_other;
    end
  end

  // reciprocal estimate is at most one low
  logic [X_W-1:0] approx;
  logic [X_W+1:0] rem3;
  logic [W_W-1:0] w_gc;

  assign approx = s2_prod[K_W +: X_W];
  assign rem3   = {2'b00, s2_x} - (X_W+2)'(3) * {2'b00, approx};

  always_comb begin
    if (s2_zero) begin
      w_gc = '0;
    end else if (s2_sat) begin
      w_gc = ONE_Q16;
    end else if (rem3 >= (X_W+2)'(3)) begin
      w_gc = W_W'(approx + X_W'(1));
    end else begin
      w_gc = W_W'(approx);
    end
  end

  logic           s3_vld;
  side_t          s3_side;
  logic [W_W-1:0] s3_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (en) begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_side <= s2_side;
      s3_w    <= (s2_side.mode == MODE_GC) ? w_gc : s2_other;
    end
  end

  assign out_vld  = s3_vld;
  assign out_side = s3_side;
  assign out_w    = s3_w;

endmodule

// ----- hw/rtl/distance_taper_weighting.sv -----
// one item per cycle sustained while results are taken from the output; the
// pipeline depth is set by the two dividers, which resolve one quotient bit per stage
// (17 stages for the ratio, 21 for the 16/r term); the pipeline stalls as a whole
// reset: synchronous, active high; clears all valid bits, support_length to 1
// and taper_mode to Gaspari-Cohn; no clearing pass, ready right after reset
module distance_taper_weighting import dtw_pkg::*; (
  input logic       clk,
  input logic       rst,
  dtw_in_if.sink    samples,
  dtw_out_if.source results,
  dtw_cfg_if.sink   cfg
);

  logic [LEN_W-1:0] support_length;
  taper_mode_t      taper_mode;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      support_length <= LEN_W'(1);
      taper_mode     <= MODE_GC;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_SUPPORT_LENGTH: support_length <= cfg.data[LEN_W-1:0];
        REG_TAPER_MODE:     taper_mode <= taper_mode_t'(cfg.data[1:0]);
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !results.valid || results.ready;
  assign samples.ready = en;

  // entry stage: length guard and support test
  logic [LEN_W-1:0] len_eff;
  logic [CMP_W-1:0] d_ext;
  side_t            side_in;

  assign len_eff = (support_length == '0) ? LEN_W'(1) : support_length;
  assign d_ext   = CMP_W'(samples.distance);

  always_comb begin
    side_in.value    = samples.sample_value;
    side_in.mode     = taper_mode;
    side_in.in_range = d_ext < CMP_W'({len_eff, 1'b0});
  end

  logic             s0_vld;
  side_t            s0_side;
  logic [Q_W-1:0]   s0_d;
  logic [LEN_W-1:0] s0_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (en) begin
      s0_vld <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_side <= side_in;
      s0_d    <= d_ext[Q_W-1:0];
      s0_len  <= len_eff;
    end
  end

  logic           r_vld;
  side_t          r_side;
  logic [Q_W-1:0] r_q;

  dtw_ratio_div u_ratio (
    .clk(clk), .rst(rst), .en(en),
    .in_vld(s0_vld), .in_side(s0_side), .in_d(s0_d), .in_len(s0_len),
    .out_vld(r_vld), .out_side(r_side), .out_q(r_q)
  );

  logic           c_vld;
  side_t          c_side;
  logic [Q_W-1:0] c_q;
  logic [T_W-1:0] c_t;

  dtw_recip_div u_recip (
    .clk(clk), .rst(rst), .en(en),
    .in_vld(r_vld), .in_side(r_side), .in_q(r_q),
    .out_vld(c_vld), .out_side(c_side), .out_q(c_q), .out_t(c_t)
  );

  logic           w_vld;
  side_t          w_side;
  logic [W_W-1:0] w_val;

  dtw_weight u_weight (
    .clk(clk), .rst(rst), .en(en),
    .in_vld(c_vld), .in_side(c_side), .in_q(c_q), .in_t(c_t),
    .out_vld(w_vld), .out_side(w_side), .out_w(w_val)
  );

  // value times weight, round half up, then saturate to the value range
  localparam int M_W = VALUE_W + W_W + 1;
  localparam logic signed [M_W-1:0] MAXV = M_W'((1 << (VALUE_W - 1)) - 1);
  localparam logic signed [M_W-1:0] MINV = -MAXV - M_W'(1);

  logic                  m1_vld;
  logic signed [M_W-1:0] m1_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
    end else if (en) begin
      m1_vld <= w_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_prod <= M_W'(w_side.value) * signed'({1'b0, w_val}) + M_W'(32768);
    end
  end

  logic signed [M_W-1:0]     m1_sh;
  logic signed [VALUE_W-1:0] sat_val;

  assign m1_sh = m1_prod >>> FRAC;

  always_comb begin
    if (m1_sh > MAXV) begin
      sat_val = MAXV[VALUE_W-1:0];
    end else if (m1_sh < MINV) begin
      sat_val = MINV[VALUE_W-1:0];
    end else begin
      sat_val = m1_sh[VALUE_W-1:0];
    end
  end

  logic                      o_vld;
  logic signed [VALUE_W-1:0] o_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (en) begin
      o_vld <= m1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_value <= sat_val;
    end
  end

  assign results.valid          = o_vld;
  assign results.weighted_value = o_value;

`ifndef ASSERT_OFF
  a_weight_max: assert property (@(posedge clk) disable iff (rst)
    w_vld |-> w_val <= ONE_Q16)
    else $error("taper weight above one");

  a_out_of_support: assert property (@(posedge clk) disable iff (rst)
    w_vld && !w_side.in_range && (w_side.mode != MODE_NONE) |-> w_val == '0)
    else $error("nonzero weight outside support");

  a_pass_through: assert property (@(posedge clk) disable iff (rst)
    w_vld && (w_side.mode == MODE_NONE) |-> w_val == ONE_Q16)
    else $error("pass-through weight not one");

  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !results.valid)
    else $error("result valid right after reset");
`endif

endmodule
